// ===== sv/cea_pkg.sv =====
// Shared types, constants and operation codes for the complex elementwise ALU.
// Used by cea_front, cea_queue, cea_back and complex_elementwise_alu.
package cea_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int FUNC_BITS = 4;
  localparam int STAT_BITS = 2;
  // Magnitude of an exact sum of two full products.
  localparam int MAG_BITS = 2 * WORD_BITS + 1;
  // Quotient bits kept by the divider; anything larger saturates.
  localparam int QUOT_BITS = WORD_BITS;
  localparam int REM_BITS = MAG_BITS + WORD_BITS + FRAC_BITS;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [FUNC_BITS-1:0] FUNC_ADD   = 4'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SUB   = 4'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_MUL   = 4'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_DIV   = 4'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_EQ    = 4'd4;
  localparam logic [FUNC_BITS-1:0] FUNC_NE    = 4'd5;
  localparam logic [FUNC_BITS-1:0] FUNC_ADDR  = 4'd6;
  localparam logic [FUNC_BITS-1:0] FUNC_SUBR  = 4'd7;
  localparam logic [FUNC_BITS-1:0] FUNC_SCALE = 4'd8;
  localparam logic [FUNC_BITS-1:0] FUNC_DIVR  = 4'd9;

  localparam logic [STAT_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_SAT  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_DIVZ = 2'd2;

  localparam logic [MAG_BITS-1:0] LIM_POS = (MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(1);
  localparam logic [MAG_BITS-1:0] LIM_NEG = MAG_BITS'(1) << (WORD_BITS - 1);
  localparam logic [MAG_BITS-1:0] ONE_MAG =
      (FRAC_BITS >= WORD_BITS - 1) ? LIM_POS : (MAG_BITS'(1) << FRAC_BITS);

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic                last;
    logic                div;
    logic                dz;
    logic                neg_re;
    logic                neg_im;
    logic [MAG_BITS-1:0] mag_re;
    logic [MAG_BITS-1:0] mag_im;
    logic [MAG_BITS-1:0] den;
  } work_t;

endpackage

// ===== sv/cea_front.sv =====
// Front end: accepts words, forms all products, classifies the operation.
// Depends on cea_pkg.
module cea_front import cea_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [FUNC_BITS-1:0]        func_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  input  logic                        last_in_i,
  output logic                        push_o,
  input  logic                        full_i,
  output work_t                       word_o
);

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = MAG_BITS + 1;

  logic                        fen;
  logic                        s1_v_q, s2_v_q;
  logic [FUNC_BITS-1:0]        s1_func_q;
  logic                        s1_last_q;
  logic signed [WORD_BITS-1:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;
  logic signed [PW-1:0]        p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_bb_q, p_cc_q;
  work_t                       w_d, w_q;

  function automatic logic [MAG_BITS-1:0] abs_mag(input logic signed [SW-1:0] v);
    logic [SW-1:0] u;
    u = v[SW-1] ? -v : v;
    return u[MAG_BITS-1:0];
  endfunction

  assign fen        = !s2_v_q || !full_i;
  assign in_stall_o = !fen;
  assign push_o     = s2_v_q && !full_i;
  assign word_o     = w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (fen) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      s1_func_q <= func_i;
      s1_last_q <= last_in_i;
      s1_ar_q   <= a_re_i;
      s1_ai_q   <= a_im_i;
      s1_br_q   <= b_re_i;
      s1_bi_q   <= b_im_i;
      p_rr_q    <= a_re_i * b_re_i;
      p_ii_q    <= a_im_i * b_im_i;
      p_ir_q    <= a_im_i * b_re_i;
      p_ri_q    <= a_re_i * b_im_i;
      p_bb_q    <= b_re_i * b_re_i;
      p_cc_q    <= b_im_i * b_im_i;
      w_q       <= w_d;
    end
  end

  always_comb begin
    logic signed [SW-1:0] sr, si;
    sr = '0;
    si = '0;
    w_d = '0;
    w_d.last = s1_last_q;
    case (s1_func_q)
      FUNC_ADD, FUNC_SUB, FUNC_ADDR, FUNC_SUBR: begin
        if (s1_func_q == FUNC_SUB || s1_func_q == FUNC_SUBR) begin
          sr = SW'(s1_ar_q) - SW'(s1_br_q);
        end else begin
          sr = SW'(s1_ar_q) + SW'(s1_br_q);
        end
        if (s1_func_q == FUNC_ADD) begin
          si = SW'(s1_ai_q) + SW'(s1_bi_q);
        end else if (s1_func_q == FUNC_SUB) begin
          si = SW'(s1_ai_q) - SW'(s1_bi_q);
        end else begin
          si = SW'(s1_ai_q);
        end
        w_d.neg_re = sr[SW-1];
        w_d.neg_im = si[SW-1];
        w_d.mag_re = abs_mag(sr);
        w_d.mag_im = abs_mag(si);
      end
      FUNC_MUL, FUNC_SCALE: begin
        if (s1_func_q == FUNC_MUL) begin
          sr = SW'(p_rr_q) - SW'(p_ii_q);
          si = SW'(p_ir_q) + SW'(p_ri_q);
        end else begin
          sr = SW'(p_rr_q);
          si = SW'(p_ir_q);
        end
        w_d.neg_re = sr[SW-1];
        w_d.neg_im = si[SW-1];
        w_d.mag_re = abs_mag(sr) >> FRAC_BITS;
        w_d.mag_im = abs_mag(si) >> FRAC_BITS;
      end
      FUNC_DIV: begin
        if (s1_br_q == '0 && s1_bi_q == '0) begin
          w_d.dz = 1'b1;
        end else begin
          sr = SW'(p_rr_q) + SW'(p_ii_q);
          si = SW'(p_ir_q) - SW'(p_ri_q);
          w_d.div    = 1'b1;
          w_d.neg_re = sr[SW-1];
          w_d.neg_im = si[SW-1];
          w_d.mag_re = abs_mag(sr);
          w_d.mag_im = abs_mag(si);
          w_d.den    = abs_mag(SW'(p_bb_q) + SW'(p_cc_q));
        end
      end
      FUNC_DIVR: begin
        if (s1_br_q == '0) begin
          w_d.dz = 1'b1;
        end else begin
          w_d.div    = 1'b1;
          w_d.neg_re = s1_ar_q[WORD_BITS-1] ^ s1_br_q[WORD_BITS-1];
          w_d.neg_im = s1_ai_q[WORD_BITS-1] ^ s1_br_q[WORD_BITS-1];
          w_d.mag_re = abs_mag(SW'(s1_ar_q));
          w_d.mag_im = abs_mag(SW'(s1_ai_q));
          w_d.den    = abs_mag(SW'(s1_br_q));
        end
      end
      FUNC_EQ: begin
        w_d.mag_re = (s1_ar_q == s1_br_q) ? ONE_MAG : '0;
        w_d.mag_im = (s1_ai_q == s1_bi_q) ? ONE_MAG : '0;
      end
      FUNC_NE: begin
        w_d.mag_re = (s1_ar_q != s1_br_q) ? ONE_MAG : '0;
        w_d.mag_im = (s1_ai_q != s1_bi_q) ? ONE_MAG : '0;
      end
      default: begin
        w_d.mag_re = '0;
      end
    endcase
  end

endmodule

// ===== sv/cea_queue.sv =====
// Short first-in first-out queue of classified words between front and back.
// Depends on cea_pkg.
module cea_queue import cea_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output work_t data_o
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  work_t               mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_q, rd_q;
  logic [CNT_BITS-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_BITS'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_q + PTR_BITS'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_q + PTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
`endif

endmodule

// ===== sv/cea_back.sv =====
// Back end: pipelined restoring divider, saturation and the output register.
// Depends on cea_pkg.
module cea_back import cea_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  work_t                       data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] r_re_o,
  output logic signed [WORD_BITS-1:0] r_im_o,
  output logic [STAT_BITS-1:0]        status_o,
  output logic                        last_out_o
);

  typedef struct packed {
    logic                 last;
    logic                 div;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic [MAG_BITS-1:0]  den;
    logic [REM_BITS-1:0]  rem_re;
    logic [REM_BITS-1:0]  rem_im;
    logic [QUOT_BITS-1:0] quo_re;
    logic [QUOT_BITS-1:0] quo_im;
  } stage_t;

  logic   ben;
  stage_t b0;
  stage_t st_q [QUOT_BITS+1];
  logic   v_q [QUOT_BITS+1];
  logic   out_v_q;
  logic signed [WORD_BITS-1:0] r_re_q, r_im_q;
  logic [STAT_BITS-1:0] stat_q;
  logic                 last_q;

  assign ben   = !out_v_q || !out_stall_i;
  assign pop_o = ben && valid_i;

  // Entry stage: numerators scaled by 2^F, early overflow check against
  // the largest quotient the stages can produce.
  always_comb begin
    logic [REM_BITS-1:0] top;
    b0 = '0;
    b0.last   = data_i.last;
    b0.div    = data_i.div;
    b0.dz     = data_i.dz;
    b0.neg_re = data_i.neg_re;
    b0.neg_im = data_i.neg_im;
    b0.den    = data_i.den;
    top = REM_BITS'(data_i.den) << QUOT_BITS;
    if (data_i.div) begin
      b0.rem_re = REM_BITS'(data_i.mag_re) << FRAC_BITS;
      b0.rem_im = REM_BITS'(data_i.mag_im) << FRAC_BITS;
    end else begin
      b0.rem_re = REM_BITS'(data_i.mag_re);
      b0.rem_im = REM_BITS'(data_i.mag_im);
    end
    b0.ovf_re = data_i.div && (b0.rem_re >= top);
    b0.ovf_im = data_i.div && (b0.rem_im >= top);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ben) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      st_q[0] <= b0;
    end
  end

  // One quotient bit per stage. Words that do not divide carry a zero
  // divisor, so their remainder passes through untouched.
  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_div
    localparam int K = QUOT_BITS - 1 - i;
    stage_t              nx;
    logic [REM_BITS-1:0] sh;
    logic                ge_re, ge_im;

    always_comb begin
      sh    = REM_BITS'(st_q[i].den) << K;
      ge_re = st_q[i].rem_re >= sh;
      ge_im = st_q[i].rem_im >= sh;
      nx    = st_q[i];
      nx.rem_re = ge_re ? st_q[i].rem_re - sh : st_q[i].rem_re;
      nx.rem_im = ge_im ? st_q[i].rem_im - sh : st_q[i].rem_im;
      nx.quo_re = {st_q[i].quo_re[QUOT_BITS-2:0], ge_re};
      nx.quo_im = {st_q[i].quo_im[QUOT_BITS-2:0], ge_im};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (ben) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ben) begin
        st_q[i+1] <= nx;
      end
    end
  end

  // Final clamp to the word range.
  logic [MAG_BITS-1:0]  fm_re, fm_im;
  logic                 sat_re, sat_im;
  logic [WORD_BITS-1:0] wd_re, wd_im;
  logic [STAT_BITS-1:0] stat_d;

  always_comb begin
    stage_t f;
    f = st_q[QUOT_BITS];
    fm_re = f.div ? MAG_BITS'(f.quo_re) : f.rem_re[MAG_BITS-1:0];
    fm_im = f.div ? MAG_BITS'(f.quo_im) : f.rem_im[MAG_BITS-1:0];
    sat_re = f.ovf_re || (f.neg_re ? (fm_re > LIM_NEG) : (fm_re > LIM_POS));
    sat_im = f.ovf_im || (f.neg_im ? (fm_im > LIM_NEG) : (fm_im > LIM_POS));
    if (sat_re) begin
      wd_re = f.neg_re ? LIM_NEG[WORD_BITS-1:0] : LIM_POS[WORD_BITS-1:0];
    end else begin
      wd_re = f.neg_re ? -fm_re[WORD_BITS-1:0] : fm_re[WORD_BITS-1:0];
    end
    if (sat_im) begin
      wd_im = f.neg_im ? LIM_NEG[WORD_BITS-1:0] : LIM_POS[WORD_BITS-1:0];
    end else begin
      wd_im = f.neg_im ? -fm_im[WORD_BITS-1:0] : fm_im[WORD_BITS-1:0];
    end
    if (f.dz) begin
      stat_d = ST_DIVZ;
    end else if (sat_re || sat_im) begin
      stat_d = ST_SAT;
    end else begin
      stat_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ben) begin
      out_v_q <= v_q[QUOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      r_re_q <= wd_re;
      r_im_q <= wd_im;
      stat_q <= stat_d;
      last_q <= st_q[QUOT_BITS].last;
    end
  end

  assign out_valid_o = out_v_q;
  assign r_re_o      = r_re_q;
  assign r_im_o      = r_im_q;
  assign status_o    = stat_q;
  assign last_out_o  = last_q;

`ifndef SYNTH
  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_DIVZ) |-> (r_re_o == '0 && r_im_o == '0))
    else $error("divide by zero word carries a nonzero result");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_SAT || status_o == ST_DIVZ))
    else $error("undefined status code");
`endif

endmodule

// ===== sv/complex_elementwise_alu.sv =====
// Top level of the complex elementwise ALU: front end, queue and back end.
// Depends on cea_pkg, cea_front, cea_queue and cea_back.
//
// Usage: each input word carries one element pair (a, b) of two complex
// Q16.16 vectors, an operation code and a last flag. Each accepted word
// yields exactly one output word with the complex result, a status code
// (ok, saturated, divide by zero) and the copied last flag, in order.
// Both channels use valid and stall: a word moves at a rising edge where
// valid is high and stall is low.
// Throughput is one word per cycle for every operation, divide included,
// while out_stall_i stays low. From input acceptance to output valid a
// word passes two front stages (products, then classification), a slot
// in the queue, the divider entry stage, 32 divider stages that each settle
// one quotient bit, and the output register. Non-divide operations ride
// the same stages, so results never reorder.
// When the receiver stalls, the back end holds; the queue keeps taking
// words from the front end until it fills, and only then is in_stall_o
// raised. Reset clears all valid bits and the queue; no word is in flight
// after reset.
module complex_elementwise_alu import cea_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [FUNC_BITS-1:0]        func_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  input  logic                        last_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] r_re_o,
  output logic signed [WORD_BITS-1:0] r_im_o,
  output logic [STAT_BITS-1:0]        status_o,
  output logic                        last_out_o
);

  logic  push, full, pop, empty;
  work_t front_word, back_word;

  // Front end: one multiplier per product, then the per-operation setup.
  cea_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .a_re_i     (a_re_i),
    .a_im_i     (a_im_i),
    .b_re_i     (b_re_i),
    .b_im_i     (b_im_i),
    .last_in_i  (last_in_i),
    .push_o     (push),
    .full_i     (full),
    .word_o     (front_word)
  );

  // The queue decouples the two halves so each can stall on its own.
  cea_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_word),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (back_word)
  );

  // Back end: divider pipeline, saturation, output register.
  cea_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (!empty),
    .data_i      (back_word),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .r_re_o      (r_re_o),
    .r_im_o      (r_im_o),
    .status_o    (status_o),
    .last_out_o  (last_out_o)
  );

endmodule
